[rtl/olm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olm_pkg
// Shared widths, codes and control structs for the ordered list mover.
// ----------------------------------------------------------------------------
package olm_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  localparam int unsigned LEN_W = 7;
  localparam int unsigned ID_W  = 7;
  localparam int unsigned OFF_W = 7;
  localparam int unsigned POS_W = 6;

  typedef enum logic {
    OP_MOVE = 1'b0,
    OP_READ = 1'b1
  } olm_op_t;

  // Row-wide command to every cell
  typedef struct packed {
    logic              init;     // reload identity order
    logic              shift;    // apply the move below
    logic [POS_W-1:0]  src_pos;  // old position of the moved entry
    logic [POS_W-1:0]  dst_pos;  // new position of the moved entry
    logic [ID_W-1:0]   id;       // identifier dropped in at dst_pos
  } olm_cell_ctrl_t;

  // Broadcast lookup keys
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [POS_W-1:0]  ridx;
  } olm_probe_t;

endpackage
`default_nettype wire

[rtl/olm_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olm_ifs
// Valid/ready channels for request, result and length configuration beats.
// ----------------------------------------------------------------------------
interface olm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic        [olm_pkg::ID_W-1:0]     entry_id;
  logic signed [olm_pkg::OFF_W-1:0]    offset;
  logic        [olm_pkg::POS_W-1:0]    read_index;

  modport source (output valid, operation, entry_id, offset, read_index, input ready);
  modport sink   (input valid, operation, entry_id, offset, read_index, output ready);
endinterface

interface olm_out_if;
  logic                              valid;
  logic                              ready;
  logic [olm_pkg::ID_W-1:0]          entry;
  logic [olm_pkg::POS_W-1:0]         position;
  logic                              error;

  modport source (output valid, entry, position, error, input ready);
  modport sink   (input valid, entry, position, error, output ready);
endinterface

interface olm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [olm_pkg::LEN_W-1:0]         list_length;

  modport source (output valid, list_length, input ready);
  modport sink   (input valid, list_length, output ready);
endinterface
`default_nettype wire

[rtl/olm_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olm_cell
// One list slot: holds an identifier, matches lookups, shifts from neighbours.
// ----------------------------------------------------------------------------
module olm_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  olm_pkg::olm_cell_ctrl_t      ctrl,
  input  olm_pkg::olm_probe_t          probe,
  input  wire [olm_pkg::ID_W-1:0]      left_val,
  input  wire [olm_pkg::ID_W-1:0]      right_val,
  output logic [olm_pkg::ID_W-1:0]     val,
  output logic                         hit_id,
  output logic                         hit_rd
);

  localparam logic [olm_pkg::POS_W-1:0] MY_POS   = olm_pkg::POS_W'(INDEX);
  localparam logic [olm_pkg::ID_W-1:0]  IDENTITY = olm_pkg::ID_W'(INDEX + 1);

  logic [olm_pkg::ID_W-1:0] slot_r;
  logic [olm_pkg::ID_W-1:0] slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.init) begin
      slot_nxt = IDENTITY;
    end else if (ctrl.shift) begin
      if (MY_POS == ctrl.dst_pos) begin
        slot_nxt = ctrl.id;
      end else if ((ctrl.dst_pos > ctrl.src_pos) && (MY_POS >= ctrl.src_pos) &&
                   (MY_POS < ctrl.dst_pos)) begin
        // entry moves later: close the gap from the right
        slot_nxt = right_val;
      end else if ((ctrl.dst_pos < ctrl.src_pos) && (MY_POS > ctrl.dst_pos) &&
                   (MY_POS <= ctrl.src_pos)) begin
        slot_nxt = left_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= IDENTITY;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign val    = slot_r;
  assign hit_id = (slot_r == probe.id);
  assign hit_rd = (MY_POS == probe.ridx);

endmodule
`default_nettype wire

[rtl/ordered_list_move_by_offset.sv]
`default_nettype none
// Flow: the request beat is taken in the idle state; the move step then registers
//   the result. A locate pass over the cell row runs in the accept cycle, then
//   one shift of the whole row in the move step; no request is taken until it ends.
// A stalled result holds the row in its move step until the slot frees.
// Reset: list in identity order, length MAX_ENTRIES; no clearing pass.
// ----------------------------------------------------------------------------
// ordered_list_move_by_offset
// Ordered identifier list with move-by-offset and read-by-position requests.
// ----------------------------------------------------------------------------
module ordered_list_move_by_offset #(
  parameter int unsigned MAX_ENTRIES = olm_pkg::MAX_ENTRIES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  olm_in_if.sink     in_ch,
  olm_out_if.source  out_ch,
  olm_cfg_if.sink    cfg_ch
);

  localparam int unsigned POS_W = olm_pkg::POS_W;
  localparam int unsigned ID_W  = olm_pkg::ID_W;
  localparam int unsigned LEN_W = olm_pkg::LEN_W;
  localparam int unsigned OFF_W = olm_pkg::OFF_W;
  localparam int unsigned SUM_W = POS_W + 2;

  typedef enum logic {
    ST_IDLE,
    ST_MOVE
  } state_t;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]        len_r, len_nxt;
  logic                    op_r, op_nxt;
  logic [ID_W-1:0]         id_r, id_nxt;
  logic signed [OFF_W-1:0] off_r, off_nxt;
  logic [POS_W-1:0]        ridx_r, ridx_nxt;
  logic [POS_W-1:0]        p_r, p_nxt;
  logic [ID_W-1:0]         rd_val_r, rd_val_nxt;
  logic                    id_ok_r, id_ok_nxt;
  logic                    ridx_ok_r, ridx_ok_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]         entry_r, entry_nxt;
  logic [POS_W-1:0]        position_r, position_nxt;
  logic                    error_r, error_nxt;

  logic in_acc, cfg_acc, out_free, move_step;

  // ---- cell row ----------------------------------------------------------
  olm_pkg::olm_cell_ctrl_t ctrl;
  olm_pkg::olm_probe_t     probe;
  logic [ID_W-1:0]         slot_val [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  hit_id, hit_rd;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [ID_W-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = slot_val[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = slot_val[g+1];
    end
    olm_cell #(.INDEX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .probe     (probe),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (slot_val[g]),
      .hit_id    (hit_id[g]),
      .hit_rd    (hit_rd[g])
    );
  end

  assign probe.id   = in_ch.entry_id;
  assign probe.ridx = in_ch.read_index;

  // Locate: encode the matching cell, pick the value at the read position
  logic [POS_W-1:0] found_pos;
  logic [ID_W-1:0]  rd_hit_val;

  always_comb begin
    found_pos  = '0;
    rd_hit_val = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_id[i]) begin
        found_pos = found_pos | POS_W'(i);
      end
      if (hit_rd[i]) begin
        rd_hit_val = rd_hit_val | slot_val[i];
      end
    end
  end

  // ---- handshakes --------------------------------------------------------
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign move_step    = (state_r == ST_MOVE) && out_free;

  // ---- target of a move --------------------------------------------------
  logic signed [SUM_W-1:0] tgt_sum, last_s;
  logic                    clamp_lo, clamp_hi;
  logic [POS_W-1:0]        tgt;

  always_comb begin
    tgt_sum  = $signed(SUM_W'(p_r)) + SUM_W'(off_r);
    last_s   = $signed(SUM_W'(len_r) - SUM_W'(1));
    clamp_lo = tgt_sum[SUM_W-1];
    clamp_hi = !clamp_lo && (tgt_sum > last_s);
    if (clamp_lo) begin
      tgt = '0;
    end else if (clamp_hi) begin
      tgt = last_s[POS_W-1:0];
    end else begin
      tgt = tgt_sum[POS_W-1:0];
    end
  end

  assign ctrl.init    = cfg_acc;
  assign ctrl.shift   = move_step && (op_r == olm_pkg::OP_MOVE) && id_ok_r;
  assign ctrl.src_pos = p_r;
  assign ctrl.dst_pos = tgt;
  assign ctrl.id      = id_r;

  // ---- next state --------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    off_nxt       = off_r;
    ridx_nxt      = ridx_r;
    p_nxt         = p_r;
    rd_val_nxt    = rd_val_r;
    id_ok_nxt     = id_ok_r;
    ridx_ok_nxt   = ridx_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    entry_nxt     = entry_r;
    position_nxt  = position_r;
    error_nxt     = error_r;

    if (cfg_acc) begin
      // saturate to 1..MAX_ENTRIES
      if (cfg_ch.list_length == '0) begin
        len_nxt = LEN_W'(1);
      end else if (cfg_ch.list_length > LEN_W'(MAX_ENTRIES)) begin
        len_nxt = LEN_W'(MAX_ENTRIES);
      end else begin
        len_nxt = cfg_ch.list_length;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_ch.operation;
          id_nxt      = in_ch.entry_id;
          off_nxt     = in_ch.offset;
          ridx_nxt    = in_ch.read_index;
          p_nxt       = found_pos;
          rd_val_nxt  = rd_hit_val;
          id_ok_nxt   = (in_ch.entry_id != '0) && (in_ch.entry_id <= len_r);
          ridx_ok_nxt = (LEN_W'(in_ch.read_index) < len_r);
          state_nxt   = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (op_r == olm_pkg::OP_READ) begin
            entry_nxt    = ridx_ok_r ? rd_val_r : '0;
            position_nxt = ridx_r;
            error_nxt    = !ridx_ok_r;
          end else if (id_ok_r) begin
            entry_nxt    = id_r;
            position_nxt = tgt;
            error_nxt    = clamp_lo || clamp_hi;
          end else begin
            entry_nxt    = '0;
            position_nxt = '0;
            error_nxt    = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LEN_W'(MAX_ENTRIES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    off_r      <= off_nxt;
    ridx_r     <= ridx_nxt;
    p_r        <= p_nxt;
    rd_val_r   <= rd_val_nxt;
    id_ok_r    <= id_ok_nxt;
    ridx_ok_r  <= ridx_ok_nxt;
    entry_r    <= entry_nxt;
    position_r <= position_nxt;
    error_r    <= error_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.entry    = entry_r;
  assign out_ch.position = position_r;
  assign out_ch.error    = error_r;

  // ---- assertions --------------------------------------------------------
  a_accept_to_move: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MOVE))
    else $error("request beat did not enter the move step");

  a_no_accept_in_move: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE) |-> !in_ch.ready)
    else $error("request taken while an item is in flight");

  a_result_from_move: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_MOVE))
    else $error("result beat raised outside the move step");

  a_cfg_identity: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (slot_val[0] == ID_W'(1)))
    else $error("length write did not restore identity order");

endmodule
`default_nettype wire

[tb/ordered_list_move_by_offset_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_move_by_offset_test
// Self-checking bench for the ordered list mover. A local list model predicts
// every result beat. A checker compares each beat with the oldest prediction.
// Directed move and read cases come first, then random traffic over several
// list lengths. Both the request and result sides stall in random bursts.
// ----------------------------------------------------------------------------
module ordered_list_move_by_offset_test;

  localparam int SLOTS       = olm_pkg::MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    olm_pkg::olm_op_t                 op;
    logic [olm_pkg::ID_W-1:0]         id;
    logic signed [olm_pkg::OFF_W-1:0] off;
    logic [olm_pkg::POS_W-1:0]        ridx;
  } list_req_t;

  typedef struct packed {
    logic [olm_pkg::ID_W-1:0]   entry;
    logic [olm_pkg::POS_W-1:0]  position;
    logic                       error;
  } list_res_t;

  logic clk;
  logic rst_n;

  olm_in_if  in_bus ();
  olm_out_if out_bus ();
  olm_cfg_if cfg_bus ();

  ordered_list_move_by_offset u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // List model and pending results
  logic [olm_pkg::ID_W-1:0] order_model [SLOTS];
  int              len_model;
  list_res_t       pending_results [$];
  list_res_t       head_result;

  int  fail_count;
  int  result_count;
  int  move_count;
  int  read_count;
  int  length_writes;
  int  cycle_count;
  int  stall_left;
  bit  idling;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void load_identity(logic [olm_pkg::LEN_W-1:0] value);
    len_model = (value == 0) ? 1 : ((value > SLOTS) ? SLOTS : int'(value));
    for (int k = 0; k < SLOTS; k++)
      order_model[k] = olm_pkg::ID_W'(k + 1);
  endfunction

  // Apply one request to the model and return the beat it should produce
  function automatic list_res_t apply_request(list_req_t r);
    list_res_t res;
    int        pos;
    int        dest;
    bit        hit;
    res = '0;
    pos = 0;
    hit = 1'b0;
    if (r.op == olm_pkg::OP_READ) begin
      res.position = r.ridx;
      if (r.ridx < len_model) res.entry = order_model[r.ridx];
      else res.error = 1'b1;
    end else begin
      if (r.id >= 1 && r.id <= len_model) begin
        for (int k = 0; k < len_model; k++) begin
          if (!hit && order_model[k] == r.id) begin
            pos = k;
            hit = 1'b1;
          end
        end
      end
      if (!hit) begin
        res.error = 1'b1;
      end else begin
        dest = pos + $signed(r.off);
        if (dest < 0) begin
          dest = 0;
          res.error = 1'b1;
        end else if (dest > len_model - 1) begin
          dest = len_model - 1;
          res.error = 1'b1;
        end
        if (dest > pos) begin
          for (int k = pos; k < dest; k++) order_model[k] = order_model[k + 1];
        end else if (dest < pos) begin
          for (int k = pos; k > dest; k--) order_model[k] = order_model[k - 1];
        end
        order_model[dest] = r.id;
        res.entry = r.id;
        res.position = olm_pkg::POS_W'(dest);
      end
    end
    return res;
  endfunction

  // Result side: random ready stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if (idling && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: entry %0d position %0d error %0d",
               out_bus.entry, out_bus.position, out_bus.error);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        result_count++;
        if (out_bus.entry !== head_result.entry) begin
          $error("entry mismatch: expected %0d, got %0d", head_result.entry, out_bus.entry);
          fail_count++;
        end
        if (out_bus.position !== head_result.position) begin
          $error("position mismatch: expected %0d, got %0d",
                 head_result.position, out_bus.position);
          fail_count++;
        end
        if (out_bus.error !== head_result.error) begin
          $error("error mismatch: expected %0d, got %0d", head_result.error, out_bus.error);
          fail_count++;
        end
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with valid possibly held
  task automatic send_item(olm_pkg::olm_op_t op, int id, int off, int ridx);
    list_req_t r;
    r.op   = op;
    r.id   = olm_pkg::ID_W'(id);
    r.off  = olm_pkg::OFF_W'(off);
    r.ridx = olm_pkg::POS_W'(ridx);
    in_bus.operation  <= r.op;
    in_bus.entry_id   <= r.id;
    in_bus.offset     <= r.off;
    in_bus.read_index <= r.ridx;
    in_bus.valid      <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.insert(pending_results.size(), apply_request(r));
    if (op == olm_pkg::OP_MOVE) move_count++;
    else read_count++;
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // Hold off requests until every predicted beat has come back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_list_length(int value);
    wait_drained();
    cfg_bus.list_length <= olm_pkg::LEN_W'(value);
    cfg_bus.valid       <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    load_identity(olm_pkg::LEN_W'(value));
    length_writes++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_reset_order();
    send_item(olm_pkg::OP_READ, 0, 0, 0);
    send_item(olm_pkg::OP_READ, 0, 0, 63);
  endtask

  task automatic test_move_edges();
    send_item(olm_pkg::OP_MOVE, 1, 0, 0);      // zero offset
    send_item(olm_pkg::OP_MOVE, 1, 63, 0);     // front to back, in range
    send_item(olm_pkg::OP_READ, 0, 0, 62);
    send_item(olm_pkg::OP_MOVE, 1, -64, 0);    // clamp at the front
    send_item(olm_pkg::OP_MOVE, 64, 63, 0);    // clamp at the back
    send_item(olm_pkg::OP_MOVE, 0, 1, 0);      // identifier zero
    send_item(olm_pkg::OP_MOVE, 127, -1, 0);   // identifier far beyond the list
    send_item(olm_pkg::OP_MOVE, 65, 5, 63);    // one past the last identifier
    send_item(olm_pkg::OP_MOVE, 32, -5, 0);
  endtask

  task automatic test_length_settings();
    write_list_length(0);             // acts as a single entry
    send_item(olm_pkg::OP_MOVE, 1, 5, 0);
    send_item(olm_pkg::OP_MOVE, 1, -1, 0);
    send_item(olm_pkg::OP_MOVE, 2, 0, 0);
    send_item(olm_pkg::OP_READ, 0, 0, 0);
    send_item(olm_pkg::OP_READ, 0, 0, 1);      // read beyond the list
    send_item(olm_pkg::OP_READ, 0, 0, 63);
    write_list_length(127);           // saturates to the full list
    send_item(olm_pkg::OP_READ, 0, 0, 63);
    send_item(olm_pkg::OP_MOVE, 64, -63, 0);
    write_list_length(2);
    send_item(olm_pkg::OP_MOVE, 2, -1, 0);
    send_item(olm_pkg::OP_READ, 0, 0, 0);
    send_item(olm_pkg::OP_READ, 0, 0, 1);
    send_item(olm_pkg::OP_MOVE, 1, 63, 0);
  endtask

  // Mostly legal moves and reads with random content, the rest raw noise
  task automatic test_random_traffic(int length_value, int count, bit allow_idle);
    olm_pkg::olm_op_t op;
    int      id;
    int      off;
    int      ridx;
    int      pos;
    idling = allow_idle;
    write_list_length(length_value);
    for (int n = 0; n < count; n++) begin
      op   = olm_pkg::olm_op_t'($urandom_range(0, 1));
      id   = $urandom_range(0, 127);
      off  = $urandom_range(0, 127);
      ridx = $urandom_range(0, 63);
      if ($urandom_range(0, 99) < 85) begin
        if (op == olm_pkg::OP_MOVE) begin
          id = $urandom_range(1, len_model);
          if ($urandom_range(0, 4) < 3) begin
            pos = 0;
            for (int k = 0; k < len_model; k++)
              if (order_model[k] == id) pos = k;
            off = $urandom_range(0, len_model - 1) - pos;
          end
        end else begin
          ridx = $urandom_range(0, len_model - 1);
        end
      end
      if (n == count / 2) wait_drained();
      send_item(op, id, off, ridx);
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    idling              = 1'b1;
    stall_left          = 0;
    in_bus.valid        = 1'b0;
    in_bus.operation    = olm_pkg::OP_MOVE;
    in_bus.entry_id     = '0;
    in_bus.offset       = '0;
    in_bus.read_index   = '0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.list_length = '0;
    load_identity(olm_pkg::LEN_W'(SLOTS));
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_order();
    test_move_edges();
    test_length_settings();
    test_random_traffic(64, 80, 1'b1);
    test_random_traffic($urandom_range(2, 63), 70, 1'b1);
    test_random_traffic(5, 50, 1'b0);
    test_random_traffic($urandom_range(0, 127), 60, 1'b1);
    test_random_traffic(1, 30, 1'b1);
    test_random_traffic(64, 110, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d moves and %0d reads across %0d list length writes",
             move_count, read_count, length_writes);
    $display("%0d result beats checked, %0d mismatches", result_count, fail_count);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
